// File: rtl/fkc_pkg.sv
// fkc_pkg: widths, fixed-point constants and controller/datapath types for the
// forward kinematics chain block. No dependencies.
`default_nettype none

package fkc_pkg;

   // fraction bits of quaternion components
   localparam int QFB    = 14;
   localparam int QUAT_W = 16;
   localparam int POS_W  = 32;
   localparam int LEN_W  = 24;

   // rounded direction component width, wide enough for any QFB in range
   localparam int DQ_W  = (((34 - QFB) > QFB) ? (34 - QFB) : QFB) + 2;
   // multiplier operand and product widths
   localparam int MA_W  = DQ_W;
   localparam int MB_W  = LEN_W + 1;
   localparam int PR_W  = MA_W + MB_W;
   // accumulation width for sums of products and the constant one squared
   localparam int ACC_W = ((PR_W > (2 * QFB + 2)) ? PR_W : (2 * QFB + 2)) + 3;

   // identity w component, saturated to the component range
   localparam logic signed [QUAT_W-1:0] QUAT_ONE =
      ((1 << QFB) > 32767) ? QUAT_W'(32767) : QUAT_W'(1 << QFB);

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_Q0,
      OP_Q1,
      OP_Q2,
      OP_Q3,
      OP_QZ,
      OP_D0,
      OP_D1,
      OP_D2,
      OP_STEP,
      OP_POS,
      OP_EMIT_ROOT,
      OP_EMIT_POS
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/fkc_ctrl.sv
// fkc_ctrl: sequencer for one joint item, issues datapath operations.
// Depends on fkc_pkg.
`default_nettype none

module fkc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_first_joint,
   output logic                  req_ready,
   input  wire fkc_pkg::stat_type stat,
   output fkc_pkg::cmd_type      cmd
);
   import fkc_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_ROOT = 13'b0000000000010,
      S_Q0   = 13'b0000000000100,
      S_Q1   = 13'b0000000001000,
      S_Q2   = 13'b0000000010000,
      S_Q3   = 13'b0000000100000,
      S_QZ   = 13'b0000001000000,
      S_D0   = 13'b0000010000000,
      S_D1   = 13'b0000100000000,
      S_D2   = 13'b0001000000000,
      S_STEP = 13'b0010000000000,
      S_POS  = 13'b0100000000000,
      S_EMIT = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // no item is taken while reset is held
   assign req_ready = (state_ff == S_IDLE) && !reset;

   // next state and operation
   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = req_first_joint ? S_ROOT : S_Q0;
            end
         end
         S_ROOT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT_ROOT;
               state_in = S_Q0;
            end
         end
         S_Q0: begin
            cmd.op   = OP_Q0;
            state_in = S_Q1;
         end
         S_Q1: begin
            cmd.op   = OP_Q1;
            state_in = S_Q2;
         end
         S_Q2: begin
            cmd.op   = OP_Q2;
            state_in = S_Q3;
         end
         S_Q3: begin
            cmd.op   = OP_Q3;
            state_in = S_QZ;
         end
         S_QZ: begin
            cmd.op   = OP_QZ;
            state_in = S_D0;
         end
         S_D0: begin
            cmd.op   = OP_D0;
            state_in = S_D1;
         end
         S_D1: begin
            cmd.op   = OP_D1;
            state_in = S_D2;
         end
         S_D2: begin
            cmd.op   = OP_D2;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.op   = OP_STEP;
            state_in = S_POS;
         end
         S_POS: begin
            cmd.op   = OP_POS;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT_POS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fkc_datapath.sv
// fkc_datapath: rotation and position state, four shared multipliers with a
// product register, rounding/saturation and the result register. Depends on fkc_pkg.
`default_nettype none

module fkc_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fkc_pkg::cmd_type             cmd,
   output fkc_pkg::stat_type                 stat,
   input  wire logic                         req_first_joint,
   input  wire logic                         req_final_joint,
   input  wire logic signed [fkc_pkg::POS_W-1:0]  req_root_x,
   input  wire logic signed [fkc_pkg::POS_W-1:0]  req_root_y,
   input  wire logic signed [fkc_pkg::POS_W-1:0]  req_root_z,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0] req_rot_w,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0] req_rot_x,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0] req_rot_y,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0] req_rot_z,
   input  wire logic        [fkc_pkg::LEN_W-1:0]  req_bone_length,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [fkc_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [fkc_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [fkc_pkg::POS_W-1:0]  rsp_pos_z,
   output logic                              rsp_chain_end
);
   import fkc_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (QFB - 1);
   localparam logic signed [ACC_W-1:0] ONE2  = ACC_W'(1) << (2 * QFB);
   localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN = ~Q_MAX;
   localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(64'sh7fffffff);
   localparam logic signed [ACC_W-1:0] P_MIN = ~P_MAX;

   // round half up by QFB fraction bits
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t   = v + HALF;
      rnd = t >>> QFB;
   endfunction

   function automatic logic signed [QUAT_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
      logic signed [QUAT_W-1:0] r;
      if (v > Q_MAX) begin
         r = QUAT_W'(16'sh7fff);
      end else if (v < Q_MIN) begin
         r = QUAT_W'(16'sh8000);
      end else begin
         r = v[QUAT_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_p(input logic signed [ACC_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > P_MAX) begin
         r = POS_W'(32'sh7fffffff);
      end else if (v < P_MIN) begin
         r = POS_W'(32'sh80000000);
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // terms subtracted in each Hamilton product component, bit i = multiplier i
   function automatic logic [3:0] neg_mask(input logic [1:0] k);
      logic [3:0] m;
      case (k)
         2'd0:    m = 4'b1110;
         2'd1:    m = 4'b1000;
         2'd2:    m = 4'b0010;
         default: m = 4'b0100;
      endcase
      return m;
   endfunction

   function automatic logic signed [MA_W-1:0] ext_a(input logic signed [QUAT_W-1:0] v);
      return {{(MA_W-QUAT_W){v[QUAT_W-1]}}, v};
   endfunction

   function automatic logic signed [MB_W-1:0] ext_b(input logic signed [QUAT_W-1:0] v);
      return {{(MB_W-QUAT_W){v[QUAT_W-1]}}, v};
   endfunction

   // state kept across items
   logic signed [QUAT_W-1:0] acc_ff [4];
   logic signed [QUAT_W-1:0] acc_in [4];
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [POS_W-1:0]  pos_in [3];

   // item operands
   logic signed [QUAT_W-1:0] b_ff [4];
   logic [LEN_W-1:0]         len_ff;
   logic                     final_ff;

   // multiplier stage
   logic signed [MA_W-1:0]   ma [4];
   logic signed [MB_W-1:0]   mb [4];
   logic                     mult_en;
   logic [1:0]               mult_k;
   logic signed [PR_W-1:0]   prod_ff [4];
   logic [1:0]               prod_k_ff;

   // intermediate results
   logic signed [QUAT_W-1:0] qn_ff [3];
   logic signed [DQ_W-1:0]   dq_ff [3];

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_pos_ff [3];
   logic                     rsp_end_ff;
   logic                     emit;

   // consumer side
   logic signed [ACC_W-1:0]  s [4];
   logic signed [ACC_W-1:0]  comp_sum;
   logic signed [QUAT_W-1:0] comp_q;
   logic signed [ACC_W-1:0]  d0;
   logic signed [ACC_W-1:0]  d1;
   logic signed [ACC_W-1:0]  d2;
   logic signed [ACC_W-1:0]  d0_r;
   logic signed [ACC_W-1:0]  d1_r;
   logic signed [ACC_W-1:0]  d2_r;
   logic signed [ACC_W-1:0]  pos_sum [3];
   logic [3:0]               neg;

   // multiplier operand selection
   always_comb begin
      mult_en = 1'b0;
      mult_k  = 2'd0;
      for (int i = 0; i < 4; i++) begin
         ma[i] = '0;
         mb[i] = '0;
      end
      unique case (cmd.op) inside
         OP_Q0, OP_Q1, OP_Q2, OP_Q3: begin
            mult_en = 1'b1;
            case (cmd.op)
               OP_Q1:   mult_k = 2'd1;
               OP_Q2:   mult_k = 2'd2;
               OP_Q3:   mult_k = 2'd3;
               default: mult_k = 2'd0;
            endcase
            for (int i = 0; i < 4; i++) begin
               ma[i] = ext_a(acc_ff[i]);
               mb[i] = ext_b(b_ff[2'(i) ^ mult_k]);
            end
         end
         OP_D0: begin
            // xy, wz, xx, zz
            mult_en = 1'b1;
            ma[0] = ext_a(acc_ff[1]);
            mb[0] = ext_b(acc_ff[2]);
            ma[1] = ext_a(acc_ff[0]);
            mb[1] = ext_b(acc_ff[3]);
            ma[2] = ext_a(acc_ff[1]);
            mb[2] = ext_b(acc_ff[1]);
            ma[3] = ext_a(acc_ff[3]);
            mb[3] = ext_b(acc_ff[3]);
         end
         OP_D1: begin
            // wx, yz
            mult_en = 1'b1;
            ma[0] = ext_a(acc_ff[0]);
            mb[0] = ext_b(acc_ff[1]);
            ma[1] = ext_a(acc_ff[2]);
            mb[1] = ext_b(acc_ff[3]);
         end
         OP_STEP: begin
            mult_en = 1'b1;
            for (int i = 0; i < 3; i++) begin
               ma[i] = dq_ff[i];
               mb[i] = {1'b0, len_ff};
            end
         end
         default: begin
            mult_en = 1'b0;
         end
      endcase
   end

   // product register
   always_ff @(posedge clock) begin
      if (mult_en) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= ma[i] * mb[i];
         end
         prod_k_ff <= mult_k;
      end
   end

   // sums of registered products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s[i] = {{(ACC_W-PR_W){prod_ff[i][PR_W-1]}}, prod_ff[i]};
      end
      neg      = neg_mask(prod_k_ff);
      comp_sum = '0;
      for (int i = 0; i < 4; i++) begin
         comp_sum = neg[i] ? (comp_sum - s[i]) : (comp_sum + s[i]);
      end
      comp_q = sat_q(rnd(comp_sum));
      d0     = (s[0] - s[1]) <<< 1;
      d1     = ONE2 - ((s[2] + s[3]) <<< 1);
      d2     = (s[0] + s[1]) <<< 1;
      d0_r   = rnd(d0);
      d1_r   = rnd(d1);
      d2_r   = rnd(d2);
      for (int i = 0; i < 3; i++) begin
         pos_sum[i] = {{(ACC_W-POS_W){pos_ff[i][POS_W-1]}}, pos_ff[i]} + rnd(s[i]);
      end
   end

   // component and direction registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_Q1:   qn_ff[0] <= comp_q;
         OP_Q2:   qn_ff[1] <= comp_q;
         OP_Q3:   qn_ff[2] <= comp_q;
         OP_D1: begin
            dq_ff[0] <= d0_r[DQ_W-1:0];
            dq_ff[1] <= d1_r[DQ_W-1:0];
         end
         OP_D2:   dq_ff[2] <= d2_r[DQ_W-1:0];
         default: ;
      endcase
   end

   // rotation and position next values
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc_in[i] = acc_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
      end
      if (cmd.load && req_first_joint) begin
         acc_in[0] = QUAT_ONE;
         acc_in[1] = '0;
         acc_in[2] = '0;
         acc_in[3] = '0;
         pos_in[0] = req_root_x;
         pos_in[1] = req_root_y;
         pos_in[2] = req_root_z;
      end else if (cmd.op == OP_QZ) begin
         acc_in[0] = qn_ff[0];
         acc_in[1] = qn_ff[1];
         acc_in[2] = qn_ff[2];
         acc_in[3] = comp_q;
      end else if (cmd.op == OP_POS) begin
         for (int i = 0; i < 3; i++) begin
            pos_in[i] = sat_p(pos_sum[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= QUAT_ONE;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
         acc_ff[3] <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
   end

   // latch item operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b_ff[0]  <= req_rot_w;
         b_ff[1]  <= req_rot_x;
         b_ff[2]  <= req_rot_y;
         b_ff[3]  <= req_rot_z;
         len_ff   <= req_bone_length;
         final_ff <= req_final_joint;
      end
   end

   // result register
   assign emit          = (cmd.op == OP_EMIT_ROOT) || (cmd.op == OP_EMIT_POS);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_ff <= pos_ff;
         rsp_end_ff <= (cmd.op == OP_EMIT_POS) && final_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_pos_ff[0];
   assign rsp_pos_y     = rsp_pos_ff[1];
   assign rsp_pos_z     = rsp_pos_ff[2];
   assign rsp_chain_end = rsp_end_ff;

endmodule

`default_nettype wire

// File: rtl/forward_kinematics_chain_top.sv
// forward_kinematics_chain_top: joint-by-joint forward kinematics with a
// quaternion rotation accumulator and saturating Q16.16 position.
// Depends on fkc_pkg, fkc_ctrl and fkc_datapath.
//
// Usage:
//   req_* channel: one joint per item (local rotation Q1.14, bone length Q8.16).
//   req_first_joint starts a chain: the root position is loaded and the
//   rotation set to identity; that item gives two rsp items, the root and
//   then the joint position. Every other joint gives one rsp item.
//   rsp_chain_end is set on the position of a joint with req_final_joint.
// Timing:
//   Four shared multipliers run the Hamilton product one component per cycle,
//   then the up-axis direction products in steps D0 and D1, then the length scaling; each
//   multiply is followed by its product register. The joint position enters
//   the rsp register from S_EMIT (with req_first_joint the root item is loaded
//   first, from S_ROOT, which follows accept), on the same edge that raises
//   req_ready again; no new item is taken before the joint position of the
//   previous one is in the rsp register.
// Reset: rotation returns to identity, position to the origin, rsp empty;
// req_ready stays low while reset is held.
// Stall: the rsp register holds an item until taken; the sequencer waits
// only when it must load a new result while the previous one is still held.
`default_nettype none

module forward_kinematics_chain_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_first_joint,
   input  wire logic                               req_final_joint,
   input  wire logic signed [fkc_pkg::POS_W-1:0]   req_root_x,
   input  wire logic signed [fkc_pkg::POS_W-1:0]   req_root_y,
   input  wire logic signed [fkc_pkg::POS_W-1:0]   req_root_z,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0]  req_rot_w,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0]  req_rot_x,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0]  req_rot_y,
   input  wire logic signed [fkc_pkg::QUAT_W-1:0]  req_rot_z,
   input  wire logic        [fkc_pkg::LEN_W-1:0]   req_bone_length,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [fkc_pkg::POS_W-1:0]        rsp_pos_x,
   output logic signed [fkc_pkg::POS_W-1:0]        rsp_pos_y,
   output logic signed [fkc_pkg::POS_W-1:0]        rsp_pos_z,
   output logic                                    rsp_chain_end
);
   import fkc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   fkc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_first_joint (req_first_joint),
      .req_ready       (req_ready),
      .stat            (stat),
      .cmd             (cmd)
   );

   // arithmetic and state
   fkc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_first_joint (req_first_joint),
      .req_final_joint (req_final_joint),
      .req_root_x      (req_root_x),
      .req_root_y      (req_root_y),
      .req_root_z      (req_root_z),
      .req_rot_w       (req_rot_w),
      .req_rot_x       (req_rot_x),
      .req_rot_y       (req_rot_y),
      .req_rot_z       (req_rot_z),
      .req_bone_length (req_bone_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_chain_end   (rsp_chain_end)
   );

endmodule

`default_nettype wire
